>>> sv/shs_pkg.sv
// shared types and constants for the streaming sha-1 hash
`timescale 1ns / 1ps
package shs_pkg;

   localparam int SHS_QUEUE_DEPTH = 4;

   localparam logic [31:0] SHS_K0 = 32'h5a827999;
   localparam logic [31:0] SHS_K1 = 32'h6ed9eba1;
   localparam logic [31:0] SHS_K2 = 32'h8f1bbcdc;
   localparam logic [31:0] SHS_K3 = 32'hca62c1d6;

   localparam logic [7:0] SHS_PAD_MARK = 8'h80;
   localparam logic [5:0] SHS_LEN_POS  = 6'd56;
   localparam logic [6:0] SHS_ROUNDS   = 7'd80;

   typedef logic [4:0][31:0] shs_chain_type;

   localparam shs_chain_type SHS_INIT = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   // one queued input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } shs_entry_type;

   // back-end control of the compression unit
   typedef struct packed {
      logic       shift_en;
      logic [7:0] shift_byte;
      logic       start;
      logic       restart;
   } shs_ctl_type;

endpackage

>>> sv/shs_front.sv
// front end: accepts input words, drops idle words, queues the rest
`timescale 1ns / 1ps
module shs_front #(
   parameter int QueueDepth = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  q_valid,
   output shs_pkg::shs_entry_type q_entry,
   input  logic                  q_pop
);
   import shs_pkg::*;

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

   shs_entry_type   slot_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push;
   logic            pop;

   assign req_tready = (count_ff != CntFull);
   // a word with neither a byte nor an end mark changes nothing
   assign push       = req_tvalid && req_tready && (req_tuser || req_tlast);
   assign q_valid    = (count_ff != '0);
   assign pop        = q_pop && q_valid;
   assign q_entry    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{data_byte: req_tdata, has_byte: req_tuser, last: req_tlast};
      end
   end

endmodule

>>> sv/shs_compress.sv
// sha-1 compression unit: byte-loaded schedule window and one round per cycle
`timescale 1ns / 1ps
module shs_compress (
   input  logic                   clock,
   input  logic                   reset,
   input  shs_pkg::shs_ctl_type   ctl,
   output logic                   busy,
   output shs_pkg::shs_chain_type chain
);
   import shs_pkg::*;

   logic [31:0]   win_ff [16];
   logic [31:0]   win_in [16];
   logic [31:0]   a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]   a_in, b_in, c_in, d_in, e_in;
   logic [6:0]    round_ff, round_in;
   logic          run_ff, run_in;
   logic          fin_ff, fin_in;
   shs_chain_type chain_ff, chain_in;
   logic [31:0]   mix;
   logic [31:0]   wsched;
   logic [31:0]   wv;
   logic [31:0]   f;
   logic [31:0]   k;
   logic [31:0]   t;

   assign busy  = run_ff || fin_ff;
   assign chain = chain_ff;

   always_comb begin
      mix    = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      wsched = {mix[30:0], mix[31]};
      wv     = (round_ff < 7'd16) ? win_ff[0] : wsched;
      if (round_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = SHS_K0;
      end else if (round_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = SHS_K1;
      end else if (round_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = SHS_K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = SHS_K3;
      end
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + wv;
   end

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         win_in[i] = win_ff[i];
      end
      if (ctl.shift_en) begin
         // bytes enter at the tail, first byte ends up in the top of word 0
         for (int i = 0; i < 15; i++) begin
            win_in[i] = {win_ff[i][23:0], win_ff[i+1][31:24]};
         end
         win_in[15] = {win_ff[15][23:0], ctl.shift_byte};
      end else if (run_ff) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[15] = wv;
      end
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      round_in = round_ff;
      run_in   = run_ff;
      fin_in   = 1'b0;
      chain_in = chain_ff;
      if (ctl.restart) begin
         chain_in = SHS_INIT;
      end else if (fin_ff) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
      if (ctl.start) begin
         a_in     = chain_ff[0];
         b_in     = chain_ff[1];
         c_in     = chain_ff[2];
         d_in     = chain_ff[3];
         e_in     = chain_ff[4];
         round_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         a_in     = t;
         b_in     = a_ff;
         c_in     = {b_ff[1:0], b_ff[31:2]};
         d_in     = c_ff;
         e_in     = d_ff;
         round_in = round_ff + 1'b1;
         if (round_ff == SHS_ROUNDS - 7'd1) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         fin_ff   <= 1'b0;
         round_ff <= '0;
         chain_ff <= SHS_INIT;
      end else begin
         run_ff   <= run_in;
         fin_ff   <= fin_in;
         round_ff <= round_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      for (int i = 0; i < 16; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

endmodule

>>> sv/shs_back.sv
// back end: byte loading, padding, length, block sequencing and digest output
`timescale 1ns / 1ps
module shs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  shs_pkg::shs_entry_type q_entry,
   output logic                   q_pop,
   output shs_pkg::shs_ctl_type   ctl,
   input  logic                   busy,
   input  shs_pkg::shs_chain_type chain,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,
   output logic [2:0]             rsp_tuser,
   output logic                   rsp_tlast
);
   import shs_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MARK = 3'd1;
   localparam logic [2:0] ST_ZERO = 3'd2;
   localparam logic [2:0] ST_LEN  = 3'd3;
   localparam logic [2:0] ST_COMP = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   localparam logic [2:0] WORD_LAST = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  ret_ff, ret_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] length_ff, length_in;
   logic [2:0]  len_idx_ff, len_idx_in;
   logic [2:0]  out_cnt_ff, out_cnt_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_data_ff, out_data_in;
   logic [2:0]  out_index_ff, out_index_in;
   logic        out_last_ff, out_last_in;
   logic        put_en;
   logic [7:0]  put_byte;
   logic [2:0]  put_next;
   logic [63:0] bit_length;
   logic        load_ok;

   assign bit_length = {length_ff[60:0], 3'b000};
   assign load_ok    = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_index_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      fill_in      = fill_ff;
      length_in    = length_ff;
      len_idx_in   = len_idx_ff;
      out_cnt_in   = out_cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      put_en       = 1'b0;
      put_byte     = '0;
      put_next     = state_ff;
      ctl          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.has_byte) begin
                  put_en    = 1'b1;
                  put_byte  = q_entry.data_byte;
                  length_in = length_ff + 64'd1;
               end
               put_next = q_entry.last ? ST_MARK : ST_IDLE;
            end
         end
         ST_MARK: begin
            put_en   = 1'b1;
            put_byte = SHS_PAD_MARK;
            put_next = ST_ZERO;
         end
         ST_ZERO: begin
            if (fill_ff == SHS_LEN_POS) begin
               put_next   = ST_LEN;
               len_idx_in = '0;
            end else begin
               put_en   = 1'b1;
               put_byte = '0;
               put_next = ST_ZERO;
            end
         end
         ST_LEN: begin
            put_en     = 1'b1;
            put_byte   = bit_length[{~len_idx_ff, 3'b000} +: 8];
            len_idx_in = len_idx_ff + 1'b1;
            put_next   = (len_idx_ff == 3'd7) ? ST_OUT : ST_LEN;
         end
         ST_COMP: begin
            if (!busy) begin
               put_next = ret_ff;
            end
         end
         ST_OUT: begin
            if (load_ok) begin
               out_valid_in = 1'b1;
               out_data_in  = chain[out_cnt_ff];
               out_index_in = out_cnt_ff;
               out_last_in  = (out_cnt_ff == WORD_LAST);
               out_cnt_in   = out_cnt_ff + 1'b1;
               if (out_cnt_ff == WORD_LAST) begin
                  out_cnt_in  = '0;
                  length_in   = '0;
                  ctl.restart = 1'b1;
                  put_next    = ST_IDLE;
               end
            end
         end
         default: begin
            put_next = ST_IDLE;
         end
      endcase

      state_in = put_next;
      if (put_en) begin
         ctl.shift_en   = 1'b1;
         ctl.shift_byte = put_byte;
         fill_in        = fill_ff + 1'b1;
         // block complete: run the compression, then carry on
         if (fill_ff == 6'd63) begin
            ctl.start = 1'b1;
            ret_in    = put_next;
            state_in  = ST_COMP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         fill_ff      <= '0;
         length_ff    <= '0;
         len_idx_ff   <= '0;
         out_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fill_ff      <= fill_in;
         length_ff    <= length_in;
         len_idx_ff   <= len_idx_in;
         out_cnt_ff   <= out_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
   end

endmodule

>>> sv/sha1_stream_hash.sv
// streaming sha-1 hash top level: input queue, sequencer and compression unit
// each full 64-byte block runs the 80-round compression loop, with no words taken
// a last word adds padding bytes at one a cycle, pausing while a block compresses,
// then one or two final blocks and 5 digest words
// the QueueDepth-word input queue lets the front keep accepting during compression
// synchronous reset empties the queue and restores the initial chaining value
`timescale 1ns / 1ps
module sha1_stream_hash #(
   parameter int QueueDepth = shs_pkg::SHS_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // has_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [2:0]  rsp_tuser,   // word_index
   output logic        rsp_tlast    // last_word
);
   import shs_pkg::*;

   logic          q_valid;
   shs_entry_type q_entry;
   logic          q_pop;
   shs_ctl_type   ctl;
   logic          busy;
   shs_chain_type chain;

   shs_front #(
      .QueueDepth(QueueDepth)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   shs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .ctl        (ctl),
      .busy       (busy),
      .chain      (chain),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   shs_compress u_compress (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .busy  (busy),
      .chain (chain)
   );

endmodule
